>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the page store.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define HFPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HFPS_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> hdl/hfps_pkg.sv
// Package of the heap file page store: sizes, action and status codes.
// No dependencies.
package hfps_pkg;
    localparam int MAX_PAGES      = 32;
    localparam int SLOTS_PER_PAGE = 64;
    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int SLOT_W  = $clog2(SLOTS_PER_PAGE);
    localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
    localparam int RCNT_W  = $clog2(SLOTS_PER_PAGE + 1);
    localparam int ADDR_W  = PAGE_W + SLOT_W;
    localparam int MEM_DEPTH = MAX_PAGES * SLOTS_PER_PAGE;

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_SEARCH  = 2'd1;
    localparam logic [1:0] ACT_DISPLAY = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DISPLAY   = 3'd4;

    localparam logic [15:0] CAP_RESET = 16'd4080;
endpackage

>>> hdl/hfps_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module hfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/heap_file_page_store.sv
// Heap file page store: first-fit insert, linear search and display over up to
// MAX_PAGES pages of SLOTS_PER_PAGE records. Start is taken while busy is low;
// each result shows for one cycle on o_valid and cannot be held off. Insert
// scans one page a cycle, search reads one record a cycle from the record
// RAM within a page, and display emits one entry a cycle. The page capacity
// register is written through its own valid/ready channel.
// Uses hfps_pkg, hfps_ram and assert_macros.svh.
`include "assert_macros.svh"
module heap_file_page_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_record_size,
    input  logic signed [31:0] i_record_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [4:0]  o_page_index,
    output logic [5:0]  o_slot_index,
    output logic [6:0]  o_count,
    output logic        o_last
);
    import hfps_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_INS = 3'd1, S_SRCH = 3'd2,
                           S_DISP = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [15:0] r_cap;
    logic [PCNT_W-1:0] r_pages, n_pages;
    logic [15:0] r_used [MAX_PAGES];
    logic [RCNT_W-1:0] r_rcnt [MAX_PAGES];
    logic [1:0]  r_act;
    logic [15:0] r_size;
    logic [31:0] r_val;
    logic [PCNT_W-1:0] r_pg, n_pg;
    logic [RCNT_W-1:0] r_sl, n_sl;
    logic        r_rdv, n_rdv;
    logic [PAGE_W-1:0] r_rdpg, n_rdpg;
    logic [SLOT_W-1:0] r_rdsl, n_rdsl;

    logic        we;
    logic [PAGE_W-1:0] wpg;
    logic [SLOT_W-1:0] wsl;
    logic [ADDR_W-1:0] raddr;
    logic [31:0] rdata;

    logic        n_valid;
    logic [2:0]  n_status;
    logic [4:0]  n_pidx;
    logic [5:0]  n_sidx;
    logic [6:0]  n_cnt;
    logic        n_last;

    logic [PAGE_W-1:0] pg_i;
    logic [15:0] cur_used;
    logic [RCNT_W-1:0] cur_rcnt;
    logic        fits;
    logic [16:0] sum;

    hfps_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr({wpg, wsl}), .i_wdata(r_val),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign pg_i = r_pg[PAGE_W-1:0];
    assign cur_used = r_used[pg_i];
    assign cur_rcnt = r_rcnt[pg_i];
    assign fits = (cur_used <= r_cap) && ((r_cap - cur_used) >= r_size)
                  && (cur_rcnt < RCNT_W'(SLOTS_PER_PAGE));
    assign raddr = {pg_i, r_sl[SLOT_W-1:0]};

    always_comb begin
        n_state = r_state; n_pages = r_pages; n_pg = r_pg; n_sl = r_sl;
        n_rdv = 1'b0; n_rdpg = pg_i; n_rdsl = r_sl[SLOT_W-1:0];
        n_valid = 1'b0; n_status = ST_INSERTED; n_pidx = '0; n_sidx = '0;
        n_cnt = '0; n_last = 1'b1;
        we = 1'b0; wpg = pg_i; wsl = cur_rcnt[SLOT_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pg = '0; n_sl = '0;
                    unique case (i_action)
                        ACT_INSERT:  n_state = S_INS;
                        ACT_SEARCH:  n_state = S_SRCH;
                        ACT_DISPLAY: n_state = S_DISP;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (r_pg < r_pages) begin
                    if (fits) begin
                        we = 1'b1;
                        n_valid = 1'b1; n_pidx = 5'(pg_i); n_sidx = 6'(wsl);
                        n_state = S_IDLE;
                    end else begin
                        n_pg = r_pg + 1'b1;
                    end
                end else if (r_pages < PCNT_W'(MAX_PAGES)) begin
                    we = 1'b1; wsl = '0;
                    n_pages = r_pages + 1'b1;
                    n_valid = 1'b1; n_pidx = 5'(pg_i);
                    n_state = S_IDLE;
                end else begin
                    n_valid = 1'b1; n_status = ST_FULL;
                    n_state = S_IDLE;
                end
            end
            S_SRCH: begin
                // One read a cycle within a page; compare on the returned word.
                if (r_rdv && rdata == r_val) begin
                    n_valid = 1'b1; n_status = ST_FOUND;
                    n_pidx = 5'(r_rdpg); n_sidx = 6'(r_rdsl);
                    n_state = S_IDLE;
                end else if (r_pg >= r_pages) begin
                    if (!r_rdv) begin
                        n_valid = 1'b1; n_status = ST_NOT_FOUND;
                        n_state = S_IDLE;
                    end
                end else if (r_sl < cur_rcnt) begin
                    n_rdv = 1'b1;
                    n_sl = r_sl + 1'b1;
                end else begin
                    n_pg = r_pg + 1'b1; n_sl = '0;
                end
            end
            S_DISP: begin
                n_valid = 1'b1; n_status = ST_DISPLAY;
                if (r_sl == '0) begin
                    n_cnt = 7'(r_pages);
                    n_last = (r_pages == '0);
                    n_sl = RCNT_W'(1);
                    if (r_pages == '0) n_state = S_IDLE;
                end else begin
                    n_cnt = 7'(cur_rcnt);
                    n_last = (r_pg + 1'b1 == r_pages);
                    n_pg = r_pg + 1'b1;
                    if (n_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign sum = {1'b0, (r_pg < r_pages) ? cur_used : 16'd0} + {1'b0, r_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cap <= CAP_RESET; r_pages <= '0;
            r_rdv <= 1'b0; o_valid <= 1'b0;
            for (int i = 0; i < MAX_PAGES; i++) begin
                r_used[i] <= '0; r_rcnt[i] <= '0;
            end
        end else begin
            r_state <= n_state; r_pages <= n_pages; r_rdv <= n_rdv;
            o_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) r_cap <= i_cfg_data;
            if (we) begin
                r_used[wpg] <= sum[16] ? 16'hFFFF : sum[15:0];
                r_rcnt[wpg] <= ((r_pg < r_pages) ? cur_rcnt : '0) + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_act <= i_action; r_size <= i_record_size; r_val <= i_record_value;
        end
        r_pg <= n_pg; r_sl <= n_sl; r_rdpg <= n_rdpg; r_rdsl <= n_rdsl;
        o_status <= n_status; o_page_index <= n_pidx; o_slot_index <= n_sidx;
        o_count <= n_cnt; o_last <= n_last;
    end

    `HFPS_ASSERT(a_one_result, i_clk, i_rst_n, o_valid && o_status != ST_DISPLAY |-> o_last, "no last")
    `HFPS_ASSERT(a_pages_bound, i_clk, i_rst_n, r_pages <= PCNT_W'(MAX_PAGES), "page count overflow")
    `HFPS_ASSERT(a_act_used, i_clk, i_rst_n, r_state == S_INS |-> r_act == ACT_INSERT, "bad action")
endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench of heap_file_page_store: insert, search, display and unused-action traffic with
// capacity writes, checked against an in-bench model of the page store.
// Depends on hfps_pkg and the heap_file_page_store RTL.
module tb;
    import hfps_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] page;
        logic [5:0] slot;
        logic [6:0] count;
        logic       last;
    } t_page_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [15:0] i_record_size;
    logic signed [31:0] i_record_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [4:0]  o_page_index;
    logic [5:0]  o_slot_index;
    logic [6:0]  o_count;
    logic        o_last;

    heap_file_page_store dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_record_size(i_record_size),
        .i_record_value(i_record_value), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data), .o_valid(o_valid),
        .o_status(o_status), .o_page_index(o_page_index),
        .o_slot_index(o_slot_index), .o_count(o_count), .o_last(o_last)
    );

    // Model of the store.
    logic [15:0] capacity;
    int unsigned open_pages;
    logic [15:0] used_bytes [MAX_PAGES];
    int unsigned records_in_page [MAX_PAGES];
    logic [31:0] stored_records [MEM_DEPTH];
    logic [31:0] inserted_values [$];

    t_page_result pending_results [$];
    bit          failed;
    bit          steady_flow;
    int unsigned cycle_count;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_result(input logic [2:0] st, input int unsigned pg,
                               input int unsigned sl, input int unsigned cnt,
                               input bit lst);
        t_page_result r;
        r.status = st;
        r.page   = pg[4:0];
        r.slot   = sl[5:0];
        r.count  = cnt[6:0];
        r.last   = lst;
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic store_record(input int unsigned pg, input logic [15:0] size,
                                input logic [31:0] value);
        logic [16:0] sum;
        sum = {1'b0, used_bytes[pg]} + {1'b0, size};
        stored_records[pg * SLOTS_PER_PAGE + records_in_page[pg]] = value;
        records_in_page[pg]++;
        used_bytes[pg] = sum[16] ? 16'hFFFF : sum[15:0];
        inserted_values.insert(inserted_values.size(), value);
    endtask

    task automatic page_store_predict(input logic [1:0] action, input logic [15:0] size,
                                      input logic [31:0] value);
        int unsigned pg;
        int unsigned sl;
        bit          done;
        done = 1'b0;
        case (action)
            ACT_INSERT: begin
                for (pg = 0; pg < open_pages && !done; pg++) begin
                    if (used_bytes[pg] <= capacity && capacity - used_bytes[pg] >= size &&
                        records_in_page[pg] < SLOTS_PER_PAGE) begin
                        push_result(ST_INSERTED, pg, records_in_page[pg], 0, 1'b1);
                        store_record(pg, size, value);
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    if (open_pages < MAX_PAGES) begin
                        pg = open_pages;
                        open_pages++;
                        used_bytes[pg] = 16'd0;
                        records_in_page[pg] = 0;
                        push_result(ST_INSERTED, pg, 0, 0, 1'b1);
                        store_record(pg, size, value);
                    end else begin
                        push_result(ST_FULL, 0, 0, 0, 1'b1);
                    end
                end
            end
            ACT_SEARCH: begin
                for (pg = 0; pg < open_pages && !done; pg++) begin
                    for (sl = 0; sl < records_in_page[pg] && !done; sl++) begin
                        if (stored_records[pg * SLOTS_PER_PAGE + sl] == value) begin
                            push_result(ST_FOUND, pg, sl, 0, 1'b1);
                            done = 1'b1;
                        end
                    end
                end
                if (!done) push_result(ST_NOT_FOUND, 0, 0, 0, 1'b1);
            end
            ACT_DISPLAY: begin
                push_result(ST_DISPLAY, 0, 0, open_pages, open_pages == 0);
                for (pg = 0; pg < open_pages; pg++) begin
                    push_result(ST_DISPLAY, 0, 0, records_in_page[pg], pg + 1 == open_pages);
                end
            end
            default: ;
        endcase
    endtask

    // Each result strobe is compared with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_page_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d page=%0d slot=%0d count=%0d last=%0d",
                         $time, o_status, o_page_index, o_slot_index, o_count, o_last);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (want.status !== o_status || want.page !== o_page_index ||
                    want.slot !== o_slot_index || want.count !== o_count ||
                    want.last !== o_last) begin
                    $display("%0t: mismatch expected st=%0d pg=%0d sl=%0d cnt=%0d last=%0d",
                             $time, want.status, want.page, want.slot, want.count, want.last);
                    $display("%0t:          actual   st=%0d pg=%0d sl=%0d cnt=%0d last=%0d",
                             $time, o_status, o_page_index, o_slot_index, o_count, o_last);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (steady_flow || roll < 65) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_item(input logic [1:0] action, input logic [15:0] size,
                             input logic [31:0] value);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= action;
        i_record_size  <= size;
        i_record_value <= value;
        do @(posedge i_clk); while (busy);
        page_store_predict(action, size, value);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        capacity = cap;
    endtask

    function automatic logic [15:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return 16'($urandom_range(1, 64));
        if (roll < 85) return 16'($urandom_range(1, 600));
        if (roll < 95) return 16'($urandom_range(1, 65535));
        return 16'hFFFF;
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(3) == 0) return $urandom_range(0, 15);
        return $urandom;
    endfunction

    task automatic send_random(input int unsigned n);
        int unsigned roll;
        logic [31:0] value;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < 50) begin
                send_item(ACT_INSERT, pick_size(), pick_value());
            end else if (roll < 85) begin
                if (inserted_values.size() > 0 && $urandom_range(2) != 0)
                    value = inserted_values[$urandom_range(inserted_values.size() - 1)];
                else
                    value = pick_value();
                send_item(ACT_SEARCH, pick_size(), value);
            end else if (roll < 95) begin
                send_item(ACT_DISPLAY, pick_size(), pick_value());
            end else begin
                send_item(ACT_UNUSED, pick_size(), pick_value());
            end
            if ($urandom_range(19) == 0) steady_flow = !steady_flow;
        end
    endtask

    task automatic test_empty_and_oversize();
        send_item(ACT_DISPLAY, 16'd1, 32'd0);
        send_item(ACT_SEARCH, 16'd1, 32'd0);
        send_item(ACT_INSERT, 16'd1, 32'h7FFF_FFFF);
        // Oversized records each open a new page of their own.
        send_item(ACT_INSERT, 16'hFFFF, 32'h8000_0000);
        send_item(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(ACT_INSERT, 16'd4079, 32'd0);
        send_item(ACT_INSERT, 16'd1, 32'd5);
        send_item(ACT_SEARCH, 16'hFFFF, 32'h8000_0000);
        send_item(ACT_SEARCH, 16'd1, 32'hFFFF_FFFF);
        send_item(ACT_SEARCH, 16'd1, 32'd5);
        send_item(ACT_SEARCH, 16'd1, 32'd12345);
        send_item(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(ACT_DISPLAY, 16'd0, 32'd0);
    endtask

    task automatic test_roomy_pages();
        write_capacity(16'hFFFF);
        send_random(100);
    endtask

    task automatic test_narrow_pages();
        write_capacity(16'd300);
        send_random(60);
    endtask

    task automatic test_fill_to_full();
        write_capacity(16'd1);
        while (open_pages < MAX_PAGES)
            send_item(ACT_INSERT, 16'($urandom_range(1, 3)), pick_value());
        repeat (6) send_item(ACT_INSERT, pick_size(), pick_value());
        send_item(ACT_DISPLAY, 16'd0, 32'd0);
    endtask

    task automatic test_full_store_traffic();
        write_capacity(CAP_RESET);
        send_random(80);
    endtask

    initial begin
        start = 1'b0;
        i_action = ACT_INSERT;
        i_record_size = 16'd0;
        i_record_value = 32'sd0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 16'd0;
        i_rst_n = 1'b0;
        failed = 1'b0;
        steady_flow = 1'b0;
        cycle_count = 0;
        capacity = CAP_RESET;
        open_pages = 0;
        for (int p = 0; p < MAX_PAGES; p++) begin
            used_bytes[p] = 16'd0;
            records_in_page[p] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_oversize();
        test_roomy_pages();
        test_narrow_pages();
        test_fill_to_full();
        test_full_store_traffic();

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hdl
hdl/hfps_pkg.sv
hdl/hfps_ram.sv
hdl/heap_file_page_store.sv
tb/tb.sv
